// File: design/sqau_pkg.sv
// sqau_pkg: shared types, codes and default sizes for the stack/queue arithmetic unit.
// No dependencies; imported by sqau_alu and stack_queue_arith_unit.
`timescale 1ns / 1ps

package sqau_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [2:0] MODE_PUSH = 3'd0;
    localparam logic [2:0] MODE_PEEK = 3'd1;
    localparam logic [2:0] MODE_SUB  = 3'd2;
    localparam logic [2:0] MODE_DIV  = 3'd3;
    localparam logic [2:0] MODE_MUL  = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_DIVZ  = 2'd2;
    localparam logic [1:0] STATUS_OVF   = 2'd3;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] push_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] top_value;
        logic               peek_valid;
        logic [6:0]         depth;
    } out_item_t;

    typedef struct packed {
        logic       go;
        logic [2:0] op;
    } alu_ctl_t;

endpackage

// File: design/sqau_alu.sv
// sqau_alu: bit-serial subtract, shift-add multiply and restoring signed divide.
// Uses sqau_pkg (mode codes, alu_ctl_t). One operand bit per cycle, DATA_WIDTH steps.
`timescale 1ns / 1ps

module sqau_alu
    import sqau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  alu_ctl_t              ctl,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] result
);

    localparam int W    = DATA_WIDTH;
    localparam int CNTW = $clog2(W);
    localparam logic [CNTW-1:0] LAST = CNTW'(W - 1);

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_PRE  = 2'd1;
    localparam logic [1:0] A_RUN  = 2'd2;
    localparam logic [1:0] A_POST = 2'd3;

    logic [1:0]      astate_reg, astate_next;
    logic            done_reg, done_next;
    logic [2:0]      op_reg, op_next;
    logic [W-1:0]    x_reg, x_next;
    logic [W-1:0]    y_reg, y_next;
    logic [W-1:0]    acc_reg, acc_next;
    logic [W-1:0]    rem_reg, rem_next;
    logic            borrow_reg, borrow_next;
    logic            neg_reg, neg_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;

    logic            diff_bit;
    logic [W:0]      shifted;
    logic [W:0]      trial;

    always_comb
    begin
        astate_next = astate_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        borrow_next = borrow_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;

        diff_bit = x_reg[0] ^ y_reg[0] ^ borrow_reg;
        shifted  = {rem_reg, x_reg[W-1]};
        trial    = shifted - {1'b0, y_reg};

        case (astate_reg)
            A_IDLE:
            begin
                if (ctl.go)
                begin
                    op_next     = ctl.op;
                    x_next      = a;
                    y_next      = b;
                    acc_next    = '0;
                    rem_next    = '0;
                    borrow_next = 1'b0;
                    cnt_next    = '0;
                    neg_next    = a[W-1] ^ b[W-1];
                    astate_next = (ctl.op == MODE_DIV) ? A_PRE : A_RUN;
                end
            end
            A_PRE:
            begin
                // operand magnitudes; the most negative value stays as its own magnitude
                x_next      = x_reg[W-1] ? (~x_reg + 1'b1) : x_reg;
                y_next      = y_reg[W-1] ? (~y_reg + 1'b1) : y_reg;
                astate_next = A_RUN;
            end
            A_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                case (op_reg)
                    MODE_SUB:
                    begin
                        acc_next    = {diff_bit, acc_reg[W-1:1]};
                        borrow_next = (~x_reg[0] & y_reg[0])
                                    | (~(x_reg[0] ^ y_reg[0]) & borrow_reg);
                        x_next      = {1'b0, x_reg[W-1:1]};
                        y_next      = {1'b0, y_reg[W-1:1]};
                    end
                    MODE_MUL:
                    begin
                        acc_next = acc_reg + (y_reg[0] ? x_reg : '0);
                        x_next   = {x_reg[W-2:0], 1'b0};
                        y_next   = {1'b0, y_reg[W-1:1]};
                    end
                    MODE_DIV:
                    begin
                        rem_next = trial[W] ? shifted[W-1:0] : trial[W-1:0];
                        x_next   = {x_reg[W-2:0], ~trial[W]};
                    end
                    default:
                    begin
                    end
                endcase
                if (cnt_reg == LAST)
                begin
                    if (op_reg == MODE_DIV)
                    begin
                        astate_next = A_POST;
                    end
                    else
                    begin
                        astate_next = A_IDLE;
                        done_next   = 1'b1;
                    end
                end
            end
            A_POST:
            begin
                acc_next    = neg_reg ? (~x_reg + 1'b1) : x_reg;
                done_next   = 1'b1;
                astate_next = A_IDLE;
            end
            default:
            begin
                astate_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            astate_reg <= A_IDLE;
            done_reg   <= 1'b0;
        end
        else
        begin
            astate_reg <= astate_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        borrow_reg <= borrow_next;
        neg_reg    <= neg_next;
        cnt_reg    <= cnt_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

// File: design/stack_queue_arith_unit.sv
// stack_queue_arith_unit: top level, deque control, element memory and result register.
// Uses sqau_pkg (types, codes, defaults) and instantiates sqau_alu.
`timescale 1ns / 1ps
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low; item carries
//   mode (push, peek, sub, div, mul) and push_value. busy stays high until the result
//   has been shown.
//   Exactly one result per transaction: result_valid is high for one cycle with result
//   (status, top_value, peek_valid, depth). The receiver cannot stall; the result is
//   gone after that cycle.
//   On the way from accept to result_valid, push, peek, ignored modes and short-stack
//   rejects pass S_RD and S_OUT; a divide-by-zero reject passes S_CHK first; sub and
//   mul pass S_CHK, the bit-serial ALU (S_ALU), S_RD and S_OUT, and div adds the ALU's
//   magnitude and sign steps. The ALU takes one operand bit per cycle. One transaction
//   at a time; a new one can be accepted the cycle after result_valid.
//   cfg_we/cfg_data write queue_mode (0 push to top, 1 append at bottom); write only
//   while busy is low.
//   Reset clears head, count, queue_mode and the control state; the element memory is
//   not cleared and needs no clearing pass.
//
module stack_queue_arith_unit
    import sqau_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  item,
    output logic      result_valid,
    output out_item_t result,
    input  logic      cfg_we,
    input  logic      cfg_data
);

    localparam int W  = DATA_WIDTH;
    localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [CW-1:0] TWO_CNT   = CW'(2);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_ALU  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          queue_mode_reg;
    logic [2:0]    mode_reg, mode_next;
    logic [1:0]    status_reg, status_next;
    logic          peek_reg, peek_next;

    logic [W-1:0]  mem [DEPTH];
    logic [W-1:0]  rd_top_reg;
    logic [W-1:0]  rd_sec_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [W-1:0]  wr_data;

    logic [AW-1:0] slot_up;
    logic [AW-1:0] slot_dn;
    logic [AW:0]   tail_sum;
    logic [AW:0]   tail_wrap;
    logic [AW-1:0] tail_slot;
    logic [W+31:0] pv_ext;
    logic [W+31:0] top_ext;
    logic [CW+6:0] depth_ext;

    alu_ctl_t      alu_ctl;
    logic          alu_done;
    logic [W-1:0]  alu_result;

    assign slot_up   = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign slot_dn   = (head_reg == '0) ? LAST_SLOT : head_reg - 1'b1;
    assign tail_sum  = {1'b0, head_reg} + (AW + 1)'(count_reg);
    assign tail_wrap = (tail_sum >= DEPTH_X) ? tail_sum - DEPTH_X : tail_sum;
    assign tail_slot = tail_wrap[AW-1:0];
    assign pv_ext    = {{W{item.push_value[31]}}, item.push_value};

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        mode_next   = mode_reg;
        status_next = status_reg;
        peek_next   = peek_reg;
        wr_en       = 1'b0;
        wr_addr     = slot_up;
        wr_data     = alu_result;
        alu_ctl.go  = 1'b0;
        alu_ctl.op  = mode_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next   = item.mode;
                    status_next = STATUS_OK;
                    peek_next   = 1'b0;
                    state_next  = S_RD;
                    case (item.mode)
                        MODE_PUSH:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                count_next  = '0;
                                head_next   = '0;
                                status_next = STATUS_OVF;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_data    = pv_ext[W-1:0];
                                count_next = count_reg + 1'b1;
                                if (queue_mode_reg)
                                begin
                                    wr_addr = tail_slot;
                                end
                                else
                                begin
                                    wr_addr   = slot_dn;
                                    head_next = slot_dn;
                                end
                            end
                        end
                        MODE_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_SHORT;
                            end
                            else
                            begin
                                peek_next = 1'b1;
                            end
                        end
                        MODE_SUB, MODE_DIV, MODE_MUL:
                        begin
                            if (count_reg < TWO_CNT)
                            begin
                                status_next = STATUS_SHORT;
                            end
                            else
                            begin
                                state_next = S_CHK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CHK:
            begin
                // operands were read at the accept edge: top in rd_top, second in rd_sec
                if (mode_reg == MODE_DIV && rd_top_reg == '0)
                begin
                    status_next = STATUS_DIVZ;
                    state_next  = S_RD;
                end
                else
                begin
                    alu_ctl.go = 1'b1;
                    state_next = S_ALU;
                end
            end
            S_ALU:
            begin
                if (alu_done)
                begin
                    wr_en      = 1'b1;
                    head_next  = slot_up;
                    count_next = count_reg - 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            queue_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                queue_mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        status_reg <= status_next;
        peek_reg   <= peek_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_top_reg <= mem[head_reg];
        rd_sec_reg <= mem[slot_up];
    end

    sqau_alu #(
        .DATA_WIDTH (W)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (alu_ctl),
        .a      (rd_sec_reg),
        .b      (rd_top_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    assign top_ext   = (W + 32)'(rd_top_reg);
    assign depth_ext = (CW + 7)'(count_reg);

    assign busy                = (state_reg != S_IDLE);
    assign result_valid        = (state_reg == S_OUT);
    assign result.status       = status_reg;
    assign result.top_value    = (count_reg == '0) ? '0 : top_ext[31:0];
    assign result.peek_valid   = peek_reg;
    assign result.depth        = depth_ext[6:0];

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("element count above DEPTH");

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid && !busy)
        else $error("result strobe longer than one cycle or block not idle after it");

    a_alu_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> state_reg == S_ALU)
        else $error("ALU finished while control was not waiting");

    a_peek_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.peek_valid |-> result.status == STATUS_OK
            && result.depth != 7'd0 || result_valid && result.peek_valid
            && result.status == STATUS_OK && CW > 7)
        else $error("peek reported valid with bad status or empty store");
`endif

endmodule
